/* hw/rtl/fdrf_pkg.sv */
// Shared types and constants for the frame dirty rectangle finder.
// No dependencies; every other file refers to it by scoped names.
package fdrf_pkg;

  localparam int DIM_W        = 13;    // configured frame dimensions
  localparam int XS_W         = 12;    // rectangle start coordinates
  localparam int XE_W         = 13;    // rectangle exclusive end coordinates
  localparam int PAIR_W       = 64;    // one word of two pixels
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_DIM_DEF  = 4096;
  localparam int PIX_PER_WORD = 2;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_DISABLE = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Frame geometry as seen by the tracker.
  typedef struct packed {
    logic [DIM_W-1:0] eff_width;   // width saturated to the maximum dimension
    logic [DIM_W-1:0] eff_height;  // height saturated to the maximum dimension
    logic             full_mode;   // report the whole frame on every frame end
  } geom_t;

  // One reported rectangle.
  typedef struct packed {
    logic [XS_W-1:0] x_start;
    logic [XS_W-1:0] y_start;
    logic [XE_W-1:0] x_end;
    logic [XE_W-1:0] y_end;
    logic            full_frame;
  } rect_t;

endpackage

/* hw/rtl/fdrf_cfg_regs.sv */
// Configuration registers and saturated frame geometry.
// Depends on fdrf_pkg.
module fdrf_cfg_regs #(
  parameter int MAX_DIM = fdrf_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fdrf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [fdrf_pkg::DIM_W-1:0]     wr_data,
  output fdrf_pkg::geom_t                geom
);

  logic [fdrf_pkg::DIM_W-1:0] frame_width;
  logic [fdrf_pkg::DIM_W-1:0] frame_height;
  logic                       compare_disable;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= fdrf_pkg::FRAME_WIDTH_RST;
      frame_height    <= fdrf_pkg::FRAME_HEIGHT_RST;
      compare_disable <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        fdrf_pkg::REG_FRAME_WIDTH:     frame_width     <= wr_data;
        fdrf_pkg::REG_FRAME_HEIGHT:    frame_height    <= wr_data;
        fdrf_pkg::REG_COMPARE_DISABLE: compare_disable <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Clamp to the largest supported dimension; odd width or compare_disable forces full reports.
  always_comb begin
    geom.eff_width  = (32'(frame_width) > 32'(MAX_DIM)) ?
                      fdrf_pkg::DIM_W'(MAX_DIM) : frame_width;
    geom.eff_height = (32'(frame_height) > 32'(MAX_DIM)) ?
                      fdrf_pkg::DIM_W'(MAX_DIM) : frame_height;
    geom.full_mode  = compare_disable | frame_width[0];
  end

endmodule

/* hw/rtl/fdrf_tracker.sv */
// Raster position counters, changed-word bounds and result formation.
// Depends on fdrf_pkg.
module fdrf_tracker #(
  parameter int MAX_DIM = fdrf_pkg::MAX_DIM_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,       // advance by one word
  input  logic            diff,       // word differs from the previous frame
  input  logic            frame_end,
  input  fdrf_pkg::geom_t geom,
  output logic            res_valid,  // this word yields a rectangle
  output fdrf_pkg::rect_t res
);

  localparam int CW = $clog2(MAX_DIM);

  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] row_count, row_count_next;
  logic [CW-1:0] min_column, min_column_next;
  logic [CW-1:0] max_column, max_column_next;
  logic [CW-1:0] min_row, min_row_next;
  logic [CW-1:0] max_row, max_row_next;
  logic          change_seen, change_seen_next;

  always_comb begin
    min_column_next  = min_column;
    max_column_next  = max_column;
    min_row_next     = min_row;
    max_row_next     = max_row;
    change_seen_next = change_seen;
    if (diff) begin
      if (!change_seen || column_count < min_column) min_column_next = column_count;
      if (!change_seen || column_count > max_column) max_column_next = column_count;
      if (!change_seen || row_count < min_row)       min_row_next    = row_count;
      if (!change_seen || row_count > max_row)       max_row_next    = row_count;
      change_seen_next = 1'b1;
    end

    // Wrap the column at the frame width and the row past the last row.
    if (32'(column_count) + 32'(fdrf_pkg::PIX_PER_WORD) >= 32'(geom.eff_width)) begin
      column_count_next = '0;
      row_count_next    = (32'(row_count) + 32'd1 >= 32'(geom.eff_height)) ?
                          '0 : row_count + CW'(1);
    end else begin
      column_count_next = column_count + CW'(fdrf_pkg::PIX_PER_WORD);
      row_count_next    = row_count;
    end

    res_valid = frame_end && (geom.full_mode || change_seen_next);
    if (geom.full_mode) begin
      res.x_start    = '0;
      res.y_start    = '0;
      res.x_end      = fdrf_pkg::XE_W'(geom.eff_width);
      res.y_end      = fdrf_pkg::XE_W'(geom.eff_height);
      res.full_frame = 1'b1;
    end else begin
      res.x_start    = fdrf_pkg::XS_W'(min_column_next);
      res.y_start    = fdrf_pkg::XS_W'(min_row_next);
      res.x_end      = fdrf_pkg::XE_W'(32'(max_column_next) +
                                       32'(fdrf_pkg::PIX_PER_WORD));
      res.y_end      = fdrf_pkg::XE_W'(32'(max_row_next) + 32'd1);
      res.full_frame = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      column_count <= '0;
      row_count    <= '0;
      min_column   <= '1;
      max_column   <= '0;
      min_row      <= '1;
      max_row      <= '0;
      change_seen  <= 1'b0;
    end else if (step) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      min_column   <= min_column_next;
      max_column   <= max_column_next;
      min_row      <= min_row_next;
      max_row      <= max_row_next;
      change_seen  <= change_seen_next;
    end
  end

endmodule

/* hw/rtl/frame_dirty_rectangle_finder.sv */
// Top level of the frame dirty rectangle finder: input register, tracker and
// result register. Depends on fdrf_pkg, fdrf_cfg_regs and fdrf_tracker.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 64-bit word of the new frame
//   (new_pair), the word at the same place in the previous frame (old_pair)
//   and frame_end on the last word of a frame, in raster order.
//   Output channel (out_valid/out_ready) carries at most one rectangle per
//   frame, on the frame_end word: start coordinates inclusive, ends exclusive.
//   Nothing comes out for a frame with no change; the whole frame comes out,
//   with full_frame set, when compare_disable is set or frame_width is odd.
//   Configuration channel (cfg_valid/cfg_ready) writes frame_width,
//   frame_height and compare_disable by index; write only while idle.
// Throughput: one request per cycle while in_ready is high. Path: the accepted
//   frame_end request sits in the input register, then loads the result register,
//   which drives out_valid with the rectangle.
// Stall: while a rectangle waits on a stalled receiver, words that produce no
//   rectangle keep flowing; only a second frame_end that yields a rectangle
//   holds in the input stage, and then the input stalls.
// Reset (rst, synchronous): counters and bounds clear, both pipeline stages
//   empty, registers return to 1920 x 1080 with comparison enabled.
module frame_dirty_rectangle_finder #(
  parameter int MAX_DIM = fdrf_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fdrf_pkg::PAIR_W-1:0]    new_pair,
  input  logic [fdrf_pkg::PAIR_W-1:0]    old_pair,
  input  logic                           frame_end,
  // rectangles
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fdrf_pkg::XS_W-1:0]      rect_x_start,
  output logic [fdrf_pkg::XS_W-1:0]      rect_y_start,
  output logic [fdrf_pkg::XE_W-1:0]      rect_x_end,
  output logic [fdrf_pkg::XE_W-1:0]      rect_y_end,
  output logic                           full_frame,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdrf_pkg::DIM_W-1:0]     cfg_data
);

  fdrf_pkg::geom_t geom;
  fdrf_pkg::rect_t res;
  logic            res_valid;

  // Input stage: keep only whether the word changed, not the pixels.
  logic s1_valid;
  logic s1_diff;
  logic s1_end;
  logic s1_fire;
  logic out_free;

  // Registers accept writes at any time.
  assign cfg_ready = 1'b1;

  fdrf_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom)
  );

  // The result register frees up in the same cycle the receiver takes it.
  assign out_free = !out_valid || out_ready;
  // Advance the input stage unless it holds a rectangle with nowhere to go.
  assign s1_fire  = s1_valid && (!res_valid || out_free);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_diff <= (new_pair != old_pair);
      s1_end  <= frame_end;
    end
  end

  fdrf_tracker #(
    .MAX_DIM (MAX_DIM)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .diff      (s1_diff),
    .frame_end (s1_end),
    .geom      (geom),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load a fresh rectangle, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      rect_x_start <= res.x_start;
      rect_y_start <= res.y_start;
      rect_x_end   <= res.x_end;
      rect_y_end   <= res.y_end;
      full_frame   <= res.full_frame;
    end
  end

endmodule
